### src/sss_pkg.sv
// shared types, constants and the character table for the segment scanner
package sss_pkg;

    // counter and field widths
    localparam int COUNTER_WIDTH = 16;
    localparam int FIELD_W       = 16;
    localparam int BLINK_W       = 16;
    localparam int CHAR_W        = 8;
    localparam int SEG_W         = 7;
    localparam int DIGIT_W       = 4;
    localparam int CLEAR_W       = 3;
    localparam int SLOT_W        = 3;

    typedef logic [COUNTER_WIDTH-1:0] count_t;
    typedef logic [FIELD_W-1:0]       field_t;
    typedef logic [BLINK_W-1:0]       blink_t;
    typedef logic [CHAR_W-1:0]        char_t;
    typedef logic [SEG_W-1:0]         seg_t;
    typedef logic [DIGIT_W-1:0]       digit_t;
    typedef logic [CLEAR_W-1:0]       clear_t;
    typedef logic [SLOT_W-1:0]        slot_t;

    // scan slots
    localparam slot_t SLOT_DIGIT3 = 3'd0;
    localparam slot_t SLOT_DIGIT2 = 3'd1;
    localparam slot_t SLOT_DIGIT1 = 3'd2;
    localparam slot_t SLOT_DIGIT0 = 3'd3;
    localparam slot_t SLOT_KEY    = 3'd4;

    // digit enables
    localparam digit_t DIGIT_NONE = 4'b0000;
    localparam digit_t DIGIT_0    = 4'b0001;
    localparam digit_t DIGIT_1    = 4'b0010;
    localparam digit_t DIGIT_2    = 4'b0100;
    localparam digit_t DIGIT_3    = 4'b1000;

    localparam seg_t SEG_BLANK = 7'h00;

    // clear mask bit positions
    localparam int CLR_A    = 0;
    localparam int CLR_B    = 1;
    localparam int CLR_BOTH = 2;

    // one input request
    typedef struct packed {
        char_t  char_0;
        char_t  char_1;
        char_t  char_2;
        char_t  char_3;
        logic   key_a;
        logic   key_b;
        clear_t clear_mask;
    } req_t;

    // one result
    typedef struct packed {
        seg_t   seg_lines;
        digit_t digit_select;
        logic   key_slot;
        field_t hold_a;
        field_t hold_b;
        field_t hold_both;
        field_t idle_ticks;
    } res_t;

    // control handed from the scan sequencer to the key counters
    typedef struct packed {
        logic   advance;
        logic   key_slot;
        logic   key_a;
        logic   key_b;
        clear_t clear_mask;
    } key_ctrl_t;

    // character to segment pattern, bit0 a through bit6 g
    function automatic seg_t seg_pattern(input char_t code);
        seg_t pat;
        unique case (code)
            8'h30:   pat = 7'h3F; // '0'
            8'h31:   pat = 7'h30; // '1'
            8'h32:   pat = 7'h5B; // '2'
            8'h33:   pat = 7'h79; // '3'
            8'h34:   pat = 7'h74; // '4'
            8'h35:   pat = 7'h6D; // '5'
            8'h36:   pat = 7'h6F; // '6'
            8'h37:   pat = 7'h38; // '7'
            8'h38:   pat = 7'h7F; // '8'
            8'h39:   pat = 7'h7D; // '9'
            8'h42:   pat = 7'h67; // 'B'
            8'h45:   pat = 7'h4F; // 'E'
            8'h54:   pat = 7'h47; // 'T'
            8'h59:   pat = 7'h75; // 'Y'
            8'h6F:   pat = 7'h63; // 'o'
            8'h4F:   pat = 7'h5C; // 'O'
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

    // saturating increment of a hold or idle counter
    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : count_t'(v + count_t'(1));
    endfunction

endpackage

### src/sss_req_if.sv
// request channel: four characters, two key levels and the clear mask
interface sss_req_if import sss_pkg::*; ();
    logic   valid;
    logic   ready;
    char_t  char_0;
    char_t  char_1;
    char_t  char_2;
    char_t  char_3;
    logic   key_a;
    logic   key_b;
    clear_t clear_mask;

    modport source (
        output valid, char_0, char_1, char_2, char_3, key_a, key_b, clear_mask,
        input  ready
    );
    modport sink (
        input  valid, char_0, char_1, char_2, char_3, key_a, key_b, clear_mask,
        output ready
    );
endinterface

### src/sss_res_if.sv
// result channel: display drive and key counters for one tick
interface sss_res_if import sss_pkg::*; ();
    logic   valid;
    logic   ready;
    seg_t   seg_lines;
    digit_t digit_select;
    logic   key_slot;
    field_t hold_a;
    field_t hold_b;
    field_t hold_both;
    field_t idle_ticks;

    modport source (
        output valid, seg_lines, digit_select, key_slot, hold_a, hold_b, hold_both,
               idle_ticks,
        input  ready
    );
    modport sink (
        input  valid, seg_lines, digit_select, key_slot, hold_a, hold_b, hold_both,
               idle_ticks,
        output ready
    );
endinterface

### src/sss_scan.sv
// scan slot sequencer, blink timer and segment decode
module sss_scan import sss_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  blink_t    blink_period,
    input  req_t      req,
    output seg_t      seg_lines,
    output digit_t    digit_select,
    output logic      key_slot
);

    slot_t  slot_reg, slot_next;
    blink_t blink_count_reg, blink_count_next;
    logic   lit_reg, lit_next;
    char_t  code;
    logic   digit_slot;

    // slot decode
    always_comb
    begin
        code         = req.char_0;
        digit_select = DIGIT_NONE;
        digit_slot   = 1'b0;
        key_slot     = 1'b0;
        unique case (slot_reg)
            SLOT_DIGIT3:
            begin
                code         = req.char_0;
                digit_select = DIGIT_3;
                digit_slot   = 1'b1;
            end
            SLOT_DIGIT2:
            begin
                code         = req.char_1;
                digit_select = DIGIT_2;
                digit_slot   = 1'b1;
            end
            SLOT_DIGIT1:
            begin
                code         = req.char_2;
                digit_select = DIGIT_1;
                digit_slot   = 1'b1;
            end
            SLOT_DIGIT0:
            begin
                code         = req.char_3;
                digit_select = DIGIT_0;
                digit_slot   = 1'b1;
            end
            SLOT_KEY:
            begin
                digit_select = DIGIT_0;
                key_slot     = 1'b1;
            end
            default:
            begin
                digit_select = DIGIT_NONE;
            end
        endcase
    end

    // segments, blanked in the key slot and while the blink flag is off
    assign seg_lines = (digit_slot && lit_reg) ? seg_pattern(code) : SEG_BLANK;

    // next slot and blink timer
    always_comb
    begin
        slot_next        = (slot_reg >= SLOT_KEY) ? SLOT_DIGIT3 : slot_t'(slot_reg + 3'd1);
        blink_count_next = blink_count_reg;
        lit_next         = lit_reg;
        if (digit_slot)
        begin
            if (blink_period != '0)
            begin
                if (blink_count_reg >= blink_period)
                begin
                    blink_count_next = '0;
                    lit_next         = ~lit_reg;
                end
                else
                begin
                    blink_count_next = blink_t'(blink_count_reg + blink_t'(1));
                end
            end
            else
            begin
                if (blink_count_reg != '1)
                begin
                    blink_count_next = blink_t'(blink_count_reg + blink_t'(1));
                end
                lit_next = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg        <= SLOT_DIGIT3;
            blink_count_reg <= '0;
            lit_reg         <= 1'b1;
        end
        else if (advance)
        begin
            slot_reg        <= slot_next;
            blink_count_reg <= blink_count_next;
            lit_reg         <= lit_next;
        end
    end

endmodule

### src/sss_keys.sv
// key hold counters and idle counter
module sss_keys import sss_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  key_ctrl_t ctrl,
    output field_t    hold_a,
    output field_t    hold_b,
    output field_t    hold_both,
    output field_t    idle_ticks
);

    count_t hold_a_reg, hold_a_next;
    count_t hold_b_reg, hold_b_next;
    count_t hold_both_reg, hold_both_next;
    count_t idle_reg, idle_next;
    count_t a_clr, b_clr, both_clr;
    logic   pressed;

    // software clear first, then the key sample
    always_comb
    begin
        a_clr    = ctrl.clear_mask[CLR_A]    ? '0 : hold_a_reg;
        b_clr    = ctrl.clear_mask[CLR_B]    ? '0 : hold_b_reg;
        both_clr = ctrl.clear_mask[CLR_BOTH] ? '0 : hold_both_reg;
        pressed  = ctrl.key_slot && (ctrl.key_a || ctrl.key_b);

        hold_a_next    = a_clr;
        hold_b_next    = b_clr;
        hold_both_next = both_clr;
        if (pressed)
        begin
            hold_a_next    = '0;
            hold_b_next    = '0;
            hold_both_next = '0;
            if (ctrl.key_a && ctrl.key_b)
            begin
                hold_both_next = sat_inc(both_clr);
            end
            else if (ctrl.key_a)
            begin
                hold_a_next = sat_inc(a_clr);
            end
            else
            begin
                hold_b_next = sat_inc(b_clr);
            end
        end
        idle_next = pressed ? count_t'(1) : sat_inc(idle_reg);
    end

    // values after this tick
    assign hold_a     = field_t'(hold_a_next);
    assign hold_b     = field_t'(hold_b_next);
    assign hold_both  = field_t'(hold_both_next);
    assign idle_ticks = field_t'(idle_next);

    // counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_a_reg    <= '0;
            hold_b_reg    <= '0;
            hold_both_reg <= '0;
            idle_reg      <= '0;
        end
        else if (ctrl.advance)
        begin
            hold_a_reg    <= hold_a_next;
            hold_b_reg    <= hold_b_next;
            hold_both_reg <= hold_both_next;
            idle_reg      <= idle_next;
        end
    end

`ifndef SYNTHESIS
    // at most one hold counter is ever running
    a_one_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({hold_a_reg != '0, hold_b_reg != '0, hold_both_reg != '0}) <= 1)
        else $error("more than one hold counter non-zero");

    // a key press restarts the idle count at one
    a_idle_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.advance && ctrl.key_slot && (ctrl.key_a || ctrl.key_b)
        |=> idle_reg == count_t'(1))
        else $error("idle count not restarted by key press");
`endif

endmodule

### src/seven_segment_scan_with_key_sense.sv
// top level: request register, scan and key logic, result register
//
// channel   direction  handshake        payload
// request   in         valid / ready    char_0..char_3, key_a, key_b, clear_mask
// result    out        valid / ready    seg_lines, digit_select, key_slot, counters
// cfg       in         cfg_wr_en        cfg_wr_data = blink_period
//
// one request a cycle while the result sink keeps up; a result passes the request
// register, then the result register, before it is offered on the result channel. the
// request register lets a new request in while a finished result still waits on a
// stalled sink. reset clears the scan slot, blink timer and counters; display starts lit.
module seven_segment_scan_with_key_sense import sss_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    sss_req_if.sink      request,
    sss_res_if.source    result,
    input  logic         cfg_wr_en,
    input  blink_t       cfg_wr_data
);

    logic      req_valid_reg, req_valid_next;
    req_t      req_reg;
    logic      res_valid_reg, res_valid_next;
    res_t      res_reg, res_next;
    blink_t    blink_period_reg;
    logic      advance;
    logic      load;
    key_ctrl_t key_ctrl;

    // handshake control
    assign advance       = req_valid_reg && (!res_valid_reg || result.ready);
    assign request.ready = !req_valid_reg || advance;
    assign load          = request.valid && request.ready;

    always_comb
    begin
        req_valid_next = load ? 1'b1 : (advance ? 1'b0 : req_valid_reg);
        res_valid_next = advance ? 1'b1 : (result.ready ? 1'b0 : res_valid_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            res_valid_reg    <= 1'b0;
            blink_period_reg <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr_en)
            begin
                blink_period_reg <= cfg_wr_data;
            end
        end
    end

    // request register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg.char_0     <= request.char_0;
            req_reg.char_1     <= request.char_1;
            req_reg.char_2     <= request.char_2;
            req_reg.char_3     <= request.char_3;
            req_reg.key_a      <= request.key_a;
            req_reg.key_b      <= request.key_b;
            req_reg.clear_mask <= request.clear_mask;
        end
    end

    // scan and display
    sss_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .blink_period (blink_period_reg),
        .req          (req_reg),
        .seg_lines    (res_next.seg_lines),
        .digit_select (res_next.digit_select),
        .key_slot     (res_next.key_slot)
    );

    // key counters
    assign key_ctrl.advance    = advance;
    assign key_ctrl.key_slot   = res_next.key_slot;
    assign key_ctrl.key_a      = req_reg.key_a;
    assign key_ctrl.key_b      = req_reg.key_b;
    assign key_ctrl.clear_mask = req_reg.clear_mask;

    sss_keys u_keys (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (key_ctrl),
        .hold_a     (res_next.hold_a),
        .hold_b     (res_next.hold_b),
        .hold_both  (res_next.hold_both),
        .idle_ticks (res_next.idle_ticks)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.seg_lines    = res_reg.seg_lines;
    assign result.digit_select = res_reg.digit_select;
    assign result.key_slot     = res_reg.key_slot;
    assign result.hold_a       = res_reg.hold_a;
    assign result.hold_b       = res_reg.hold_b;
    assign result.hold_both    = res_reg.hold_both;
    assign result.idle_ticks   = res_reg.idle_ticks;

`ifndef SYNTHESIS
    // key slot shows blank segments on digit 0
    a_key_slot_blank: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.key_slot
        |-> result.seg_lines == SEG_BLANK && result.digit_select == DIGIT_0)
        else $error("key slot drives segments");

    // never more than one digit enabled
    a_digit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> $onehot0(result.digit_select))
        else $error("several digits enabled");
`endif

endmodule
